@@ design/m3e_pkg.sv @@
package m3e_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned ALPHA_BITS      = 16;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd22938;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_SMOOTHING_ALPHA = 1'b0
  } reg_idx_e;

  localparam logic [1:0] RING_LAST = 2'd2;
  localparam logic [1:0] RING_FULL = 2'd3;

  typedef struct packed {
    logic [1:0] head;
    logic [1:0] fill;
    logic       primed;
  } ring_ctrl_t;

endpackage

@@ design/m3e_datapath.sv @@
module m3e_datapath
  import m3e_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          update_i,
  input  logic signed [SAMPLE_BITS-1:0] ring0_i,
  input  logic signed [SAMPLE_BITS-1:0] ring1_i,
  input  logic signed [SAMPLE_BITS-1:0] ring2_i,
  input  ring_ctrl_t                    ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] smoothed_i,
  input  logic signed [SAMPLE_BITS-1:0] last_median_i,
  input  logic        [ALPHA_BITS-1:0]  alpha_i,
  output ring_ctrl_t                    ctrl_o,
  output logic signed [SAMPLE_BITS-1:0] smoothed_o,
  output logic signed [SAMPLE_BITS-1:0] median_o
);

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = DIFF_W + ALPHA_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] a, b, c;
  logic signed [SAMPLE_BITS-1:0] lo_ab, hi_ab, lo_hc, med;
  logic        [1:0]             fill_n;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      diff_x, alpha_x, prod, step;
  logic signed [SAMPLE_BITS-1:0] pulled;

  always_comb begin
    a = (ctrl_i.head == 2'd0) ? sample_i : ring0_i;
    b = (ctrl_i.head == 2'd1) ? sample_i : ring1_i;
    c = (ctrl_i.head == 2'd2) ? sample_i : ring2_i;
    fill_n = (ctrl_i.fill == RING_FULL) ? RING_FULL : ctrl_i.fill + 2'd1;

    lo_ab = (a < b) ? a : b;
    hi_ab = (a > b) ? a : b;
    lo_hc = (hi_ab < c) ? hi_ab : c;
    case (fill_n)
      2'd2:    med = hi_ab;
      2'd3:    med = (lo_ab > lo_hc) ? lo_ab : lo_hc;
      default: med = a;
    endcase

    diff    = DIFF_W'(med) - DIFF_W'(smoothed_i);
    diff_x  = PROD_W'(diff);
    alpha_x = PROD_W'($signed({1'b0, alpha_i}));
    prod    = diff_x * alpha_x;
    step    = prod >>> ALPHA_BITS;
    pulled  = smoothed_i + SAMPLE_BITS'(step);

    ctrl_o = ctrl_i;
    smoothed_o = smoothed_i;
    median_o = last_median_i;
    if (update_i) begin
      ctrl_o.head   = (ctrl_i.head == RING_LAST) ? 2'd0 : ctrl_i.head + 2'd1;
      ctrl_o.fill   = fill_n;
      ctrl_o.primed = 1'b1;
      median_o      = med;
      smoothed_o    = ctrl_i.primed ? pulled : med;
    end
  end

endmodule

@@ design/median3_ema_altitude_filter_core.sv @@
// Channel      Dir  Fields (lowest bit up)
// s_axis       in   tdata: sample_altitude; tuser: sample_update
// m_axis       out  tdata: smoothed_altitude, window_median
// apb          in   register 0 at byte 0: smoothing_alpha [15:0]
//
// One transaction per cycle while m_axis is not stalled; a result is offered
// once its sample has passed the input register, then the median network and
// one multiply and add into the result register and the filter state together.
// Reset clears control state, filter state and alpha (22938); the sample
// ring is not cleared. A stalled m_axis holds the result register and the
// input register still takes one more transaction.
module median3_ema_altitude_filter_core
  import m3e_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // sample_altitude
  input  logic                   s_axis_tuser_i,   // sample_update
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // smoothed_altitude, window_median
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [ALPHA_BITS-1:0]         alpha_q;
  logic                          in_vld_q, in_vld_d;
  logic signed [SAMPLE_BITS-1:0] in_smp_q;
  logic                          in_upd_q;
  logic                          out_vld_q, out_vld_d;
  logic signed [SAMPLE_BITS-1:0] out_smooth_q, out_med_q;
  logic signed [SAMPLE_BITS-1:0] ring_q [3];
  ring_ctrl_t                    ctrl_q, ctrl_d;
  logic signed [SAMPLE_BITS-1:0] smoothed_q, smoothed_d;
  logic signed [SAMPLE_BITS-1:0] median_q, median_d;
  logic                          accept, advance, load, cfg_wr;
  reg_idx_e                      reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == '0)
                   && (reg_idx == REG_SMOOTHING_ALPHA);
  assign prdata  = (reg_idx == REG_SMOOTHING_ALPHA) ? APB_DATA_W'(alpha_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else if (cfg_wr) begin
      alpha_q <= pwdata[ALPHA_BITS-1:0];
    end
  end

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign load            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  m3e_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .sample_i      (in_smp_q),
    .update_i      (in_upd_q),
    .ring0_i       (ring_q[0]),
    .ring1_i       (ring_q[1]),
    .ring2_i       (ring_q[2]),
    .ctrl_i        (ctrl_q),
    .smoothed_i    (smoothed_q),
    .last_median_i (median_q),
    .alpha_i       (alpha_q),
    .ctrl_o        (ctrl_d),
    .smoothed_o    (smoothed_d),
    .median_o      (median_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      ctrl_q     <= '0;
      smoothed_q <= '0;
      median_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (load) begin
        ctrl_q     <= ctrl_d;
        smoothed_q <= smoothed_d;
        median_q   <= median_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_smp_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      in_upd_q <= s_axis_tuser_i;
    end
    if (load) begin
      out_smooth_q <= smoothed_d;
      out_med_q    <= median_d;
      if (in_upd_q) begin
        ring_q[ctrl_q.head] <= in_smp_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_med_q, out_smooth_q});

`ifndef SYNTHESIS
  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.head != RING_FULL)
    else $error("ring head out of range");

  a_primed_has_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.primed |-> ctrl_q.fill != 2'd0)
    else $error("smoother primed with empty ring");

  a_unprimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_q.primed |-> (smoothed_q == '0) && (median_q == '0))
    else $error("held values non-zero before first update");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid_o && (out_smooth_q == smoothed_q))
    else $error("result register out of step with filter state");
`endif

endmodule
